@@ hw/rtl/aps_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adaptive pointer smoother package
// Shared constants, register map, configuration struct, sequencer states and
// the exp(-i/16) gain table for the adaptive pointer smoother.
// ----------------------------------------------------------------------------
package aps_pkg;

    // Default sizes for the top-level parameters.
    localparam int COORD_BITS_DEF = 16;
    localparam int EXP_DEPTH_DEF  = 256;
    localparam int EXP_DEPTH_MAX  = 1024;

    // Q1.16 fixed point.
    localparam int          Q16_W       = 17;
    localparam logic [16:0] ONE_Q16     = 17'h10000;
    localparam int          BLEND_SHIFT = 16;

    // The table index is the Q.16 exponent argument in Q4.4.
    localparam int IDX_SHIFT = 12;

    // Speeds are saturated to this width before the exponent multiply; any
    // larger speed with a nonzero rate lands on the last table entry anyway.
    localparam int SPEED_SAT_W = 22;

    // Width of the A operand of the shared multiplier (Q1.16 value plus sign).
    localparam int MUL_A_W = 18;

    // Configuration registers.
    localparam int          GAIN_W     = 17;
    localparam int          RATE_W     = 16;
    localparam logic [16:0] GAIN_RESET = 17'd32768;
    localparam logic [15:0] RATE_RESET = 16'd6554;

    // APB port.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_SEL_BIT = 2;

    typedef enum logic [0:0] {
        REG_GAIN_SCALE = 1'b0,
        REG_SPEED_RATE = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [GAIN_W-1:0] gain_scale;
        logic [RATE_W-1:0] speed_rate;
    } cfg_t;

    // Sequencer states of the smoothing core.
    typedef enum logic [2:0] {
        S_IDLE,
        S_DIST,
        S_RATE,
        S_LOOK,
        S_GAIN,
        S_BLEND_X,
        S_BLEND_Y,
        S_FIN
    } state_t;

    typedef logic [Q16_W-1:0] exp_table_t [0:EXP_DEPTH_MAX-1];

    // Series terms of exp(-1/16) in Q0.60; term k is term k-1 / (16 * k).
    localparam logic [63:0] EXP_T1  = (64'd1 << 60) / 64'd16;
    localparam logic [63:0] EXP_T2  = EXP_T1 / 64'd32;
    localparam logic [63:0] EXP_T3  = EXP_T2 / 64'd48;
    localparam logic [63:0] EXP_T4  = EXP_T3 / 64'd64;
    localparam logic [63:0] EXP_T5  = EXP_T4 / 64'd80;
    localparam logic [63:0] EXP_T6  = EXP_T5 / 64'd96;
    localparam logic [63:0] EXP_T7  = EXP_T6 / 64'd112;
    localparam logic [63:0] EXP_T8  = EXP_T7 / 64'd128;
    localparam logic [63:0] EXP_T9  = EXP_T8 / 64'd144;
    localparam logic [63:0] EXP_T10 = EXP_T9 / 64'd160;
    localparam logic [63:0] EXP_T11 = EXP_T10 / 64'd176;
    localparam logic [63:0] EXP_T12 = EXP_T11 / 64'd192;
    localparam logic [63:0] EXP_T13 = EXP_T12 / 64'd208;
    localparam logic [63:0] EXP_T14 = EXP_T13 / 64'd224;

    // exp(-1/16) in Q0.60, the alternating sum of the terms above.
    localparam logic [63:0] EXP_STEP_Q60 = (64'd1 << 60) - EXP_T1 + EXP_T2 - EXP_T3
                                         + EXP_T4 - EXP_T5 + EXP_T6 - EXP_T7
                                         + EXP_T8 - EXP_T9 + EXP_T10 - EXP_T11
                                         + EXP_T12 - EXP_T13 + EXP_T14;

    // (a * b) >> 60 for Q0.60 operands, split into 30-bit halves.
    function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] mask30;
        logic [63:0] a1;
        logic [63:0] a0;
        logic [63:0] b1;
        logic [63:0] b0;
        logic [63:0] mid;
        mask30 = (64'd1 << 30) - 64'd1;
        a1     = a >> 30;
        a0     = a & mask30;
        b1     = b >> 30;
        b0     = b & mask30;
        mid    = a1 * b0 + a0 * b1 + ((a0 * b0) >> 30);
        return a1 * b1 + (mid >> 30);
    endfunction

    // Builds round(65536 * exp(-i/16)) by repeated multiplication with
    // exp(-1/16); evaluated once at elaboration.
    function automatic exp_table_t build_exp_table();
        exp_table_t  tbl;
        logic [63:0] p;
        p = 64'd1 << 60;
        for (int k = 0; k < EXP_DEPTH_MAX; k++)
        begin
            tbl[k] = Q16_W'((p + (64'd1 << 43)) >> 44);
            p      = mul_q60(p, EXP_STEP_Q60);
        end
        return tbl;
    endfunction

    localparam exp_table_t EXP_TABLE = build_exp_table();

endpackage

@@ hw/rtl/aps_point_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pointer point channel
// Valid/ready channel that carries one raw pointer point per request.
// ----------------------------------------------------------------------------
interface aps_point_if #(
    parameter int COORD_BITS = aps_pkg::COORD_BITS_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic                         path_start;

    modport source (output valid, output point_x, output point_y, output path_start,
                    input ready);
    modport sink (input valid, input point_x, input point_y, input path_start,
                  output ready);
endinterface

@@ hw/rtl/aps_smooth_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Smoothed point channel
// Valid/ready channel that carries one smoothed pointer point per request.
// ----------------------------------------------------------------------------
interface aps_smooth_if #(
    parameter int COORD_BITS = aps_pkg::COORD_BITS_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] smooth_x;
    logic signed [COORD_BITS-1:0] smooth_y;

    modport source (output valid, output smooth_x, output smooth_y, input ready);
    modport sink (input valid, input smooth_x, input smooth_y, output ready);
endinterface

@@ hw/rtl/adaptive_pointer_smoother_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adaptive pointer smoother
// Speed-adaptive exponential smoothing of a pointer point stream, with an
// APB register port for the gain scale and the speed rate.
// ----------------------------------------------------------------------------
// A point that starts a path (or arrives before any path) is taken in S_IDLE
// and gives no result; the core is ready again on the next cycle. Every
// other point gives one smoothed point once it is accepted: the core steps
// through distance, exponent index, table lookup,
// gain and the x and y blends, and the four products of that chain share a
// single registered multiplier. The core is ready again as soon as the result
// is presented, so a new point is accepted only after the last result is
// presented. The result waits in an output register; the core holds its
// last step while that register is still full. Registers: gain_scale at 0x0,
// speed_rate at 0x4.
// ----------------------------------------------------------------------------
module adaptive_pointer_smoother_top #(
    parameter int COORD_BITS      = aps_pkg::COORD_BITS_DEF,
    parameter int EXP_TABLE_DEPTH = aps_pkg::EXP_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [aps_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [aps_pkg::APB_DATA_W-1:0] pwdata,
    output logic [aps_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    aps_point_if.sink                      point_in,
    aps_smooth_if.source                   smooth_out
);
    import aps_pkg::*;

    cfg_t cfg;

    // Configuration register file.
    aps_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Smoothing sequencer and datapath.
    aps_core #(
        .COORD_BITS      (COORD_BITS),
        .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .point_in   (point_in),
        .smooth_out (smooth_out)
    );

endmodule

@@ hw/rtl/aps_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Smoother configuration registers
// APB register file holding the gain scale and the speed rate.
// ----------------------------------------------------------------------------
module aps_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [aps_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [aps_pkg::APB_DATA_W-1:0] pwdata,
    output logic [aps_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output aps_pkg::cfg_t                  cfg
);
    import aps_pkg::*;

    logic [GAIN_W-1:0] gain_scale_reg;
    logic [GAIN_W-1:0] gain_scale_next;
    logic [RATE_W-1:0] speed_rate_reg;
    logic [RATE_W-1:0] speed_rate_next;
    reg_idx_t          reg_sel;
    logic              wr_en;

    // The register is chosen by the word address; byte offsets are ignored.
    assign reg_sel = reg_idx_t'(paddr[REG_SEL_BIT]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    // Register write decode.
    always_comb
    begin
        gain_scale_next = gain_scale_reg;
        speed_rate_next = speed_rate_reg;
        if (wr_en)
        begin
            case (reg_sel)
                REG_GAIN_SCALE: gain_scale_next = pwdata[GAIN_W-1:0];
                REG_SPEED_RATE: speed_rate_next = pwdata[RATE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_scale_reg <= GAIN_RESET;
            speed_rate_reg <= RATE_RESET;
        end
        else
        begin
            gain_scale_reg <= gain_scale_next;
            speed_rate_reg <= speed_rate_next;
        end
    end

    // Read mux.
    always_comb
    begin
        case (reg_sel)
            REG_GAIN_SCALE: prdata = APB_DATA_W'(gain_scale_reg);
            REG_SPEED_RATE: prdata = APB_DATA_W'(speed_rate_reg);
            default:        prdata = '0;
        endcase
    end

    assign cfg.gain_scale = gain_scale_reg;
    assign cfg.speed_rate = speed_rate_reg;

endmodule

@@ hw/rtl/aps_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared signed multiplier
// One registered signed multiplier, time-shared by the smoothing sequencer.
// ----------------------------------------------------------------------------
module aps_mul #(
    parameter int B_W = aps_pkg::SPEED_SAT_W + 1
) (
    input  logic                                      clk,
    input  logic signed [aps_pkg::MUL_A_W-1:0]        a,
    input  logic signed [B_W-1:0]                     b,
    output logic signed [aps_pkg::MUL_A_W+B_W-1:0]    prod
);
    import aps_pkg::*;

    logic signed [MUL_A_W+B_W-1:0] prod_reg;
    logic signed [MUL_A_W+B_W-1:0] prod_next;

    // Full-precision product, registered before any further use.
    assign prod_next = (MUL_A_W + B_W)'(a) * (MUL_A_W + B_W)'(b);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

@@ hw/rtl/aps_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Smoothing core
// Sequencer and datapath that seed the smoothed point and run the speed,
// gain and blend products through one shared multiplier.
// ----------------------------------------------------------------------------
module aps_core #(
    parameter int COORD_BITS      = aps_pkg::COORD_BITS_DEF,
    parameter int EXP_TABLE_DEPTH = aps_pkg::EXP_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  aps_pkg::cfg_t cfg,
    aps_point_if.sink     point_in,
    aps_smooth_if.source  smooth_out
);
    import aps_pkg::*;

    localparam int DIFF_W   = COORD_BITS + 1;
    localparam int SPEED_W  = (COORD_BITS + 2 > SPEED_SAT_W) ? COORD_BITS + 2 : SPEED_SAT_W;
    localparam int MUL_B_W  = (DIFF_W > SPEED_SAT_W + 1) ? DIFF_W : SPEED_SAT_W + 1;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int SUM_W    = PROD_W + 1;
    localparam int IDX_W    = $clog2(EXP_TABLE_DEPTH);
    localparam int IDX_HI_W = PROD_W - IDX_SHIFT;
    localparam logic [IDX_W-1:0]       IDX_MAX   = IDX_W'(EXP_TABLE_DEPTH - 1);
    localparam logic [SPEED_SAT_W-1:0] SPEED_MAX = '1;

    state_t state_reg;
    state_t state_next;

    logic                         seeded_reg;
    logic                         seeded_next;
    logic signed [COORD_BITS-1:0] last_x_reg;
    logic signed [COORD_BITS-1:0] last_x_next;
    logic signed [COORD_BITS-1:0] last_y_reg;
    logic signed [COORD_BITS-1:0] last_y_next;
    logic signed [COORD_BITS-1:0] cur_x_reg;
    logic signed [COORD_BITS-1:0] cur_x_next;
    logic signed [COORD_BITS-1:0] cur_y_reg;
    logic signed [COORD_BITS-1:0] cur_y_next;
    logic signed [DIFF_W-1:0]     diff_x_reg;
    logic signed [DIFF_W-1:0]     diff_x_next;
    logic signed [DIFF_W-1:0]     diff_y_reg;
    logic signed [DIFF_W-1:0]     diff_y_next;
    logic [SPEED_W-1:0]           speed_reg;
    logic [SPEED_W-1:0]           speed_next;
    logic [Q16_W-1:0]             exp_reg;
    logic [Q16_W-1:0]             exp_next;
    logic [Q16_W-1:0]             blend_b_reg;
    logic [Q16_W-1:0]             blend_b_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic signed [COORD_BITS-1:0] smooth_x_reg;
    logic signed [COORD_BITS-1:0] smooth_x_next;
    logic signed [COORD_BITS-1:0] smooth_y_reg;
    logic signed [COORD_BITS-1:0] smooth_y_next;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod;
    logic [PROD_W-1:0]         prod_u;

    logic signed [DIFF_W-1:0]  dx;
    logic signed [DIFF_W-1:0]  dy;
    logic [DIFF_W-1:0]         abs_dx;
    logic [DIFF_W-1:0]         abs_dy;
    logic [SPEED_SAT_W-1:0]    speed_sat;
    logic [IDX_HI_W-1:0]       idx_hi;
    logic [IDX_W-1:0]          exp_idx;
    logic [Q16_W-1:0]          gain_sat;
    logic [Q16_W-1:0]          prod_q16;
    logic signed [COORD_BITS-1:0] blend_val;

    logic in_acc;
    logic out_take;
    logic seed_point;
    logic fin_go;

    // (last * 65536 + b * (cur - last)) / 65536, truncated toward zero.
    function automatic logic signed [COORD_BITS-1:0] blend_finish(
        input logic signed [PROD_W-1:0]     p,
        input logic signed [COORD_BITS-1:0] last
    );
        logic signed [SUM_W-1:0] sum;
        logic signed [SUM_W-1:0] quo;
        sum = (SUM_W'(last) <<< BLEND_SHIFT) + SUM_W'(p);
        quo = sum >>> BLEND_SHIFT;
        if (sum[SUM_W-1] && (sum[BLEND_SHIFT-1:0] != '0))
        begin
            quo = quo + SUM_W'(1);
        end
        return quo[COORD_BITS-1:0];
    endfunction

    aps_mul #(
        .B_W (MUL_B_W)
    ) u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    assign prod_u     = prod;
    assign in_acc     = point_in.valid && point_in.ready;
    assign out_take   = smooth_out.valid && smooth_out.ready;
    assign seed_point = point_in.path_start || !seeded_reg;
    assign fin_go     = (state_reg == S_FIN) && (!out_valid_reg || smooth_out.ready);

    // Distance terms from the latched point to the smoothed point.
    assign dx     = DIFF_W'(cur_x_reg) - DIFF_W'(last_x_reg);
    assign dy     = DIFF_W'(cur_y_reg) - DIFF_W'(last_y_reg);
    assign abs_dx = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
    assign abs_dy = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);

    // Saturated speed for the exponent product.
    assign speed_sat = (speed_reg > SPEED_W'(SPEED_MAX)) ? SPEED_MAX
                                                         : speed_reg[SPEED_SAT_W-1:0];

    // Q4.4 table index, clamped at the last entry.
    assign idx_hi  = prod_u[PROD_W-1:IDX_SHIFT];
    assign exp_idx = (idx_hi > IDX_HI_W'(EXP_TABLE_DEPTH - 1)) ? IDX_MAX
                                                               : idx_hi[IDX_W-1:0];

    assign gain_sat  = (cfg.gain_scale > ONE_Q16) ? ONE_Q16 : cfg.gain_scale;
    assign prod_q16  = prod_u[BLEND_SHIFT +: Q16_W];
    assign blend_val = blend_finish(prod, (state_reg == S_FIN) ? last_y_reg : last_x_reg);

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc && !seed_point)
                begin
                    state_next = S_DIST;
                end
            end
            S_DIST:    state_next = S_RATE;
            S_RATE:    state_next = S_LOOK;
            S_LOOK:    state_next = S_GAIN;
            S_GAIN:    state_next = S_BLEND_X;
            S_BLEND_X: state_next = S_BLEND_Y;
            S_BLEND_Y: state_next = S_FIN;
            S_FIN:
            begin
                if (fin_go)
                begin
                    state_next = S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    // Outputs of the sequencer: input ready and multiplier operands.
    // While the finished point waits in S_FIN, the Y blend operands are held
    // so that the registered product stays put.
    always_comb
    begin
        point_in.ready = 1'b0;
        mul_a          = '0;
        mul_b          = '0;
        case (state_reg)
            S_IDLE:
            begin
                point_in.ready = 1'b1;
            end
            S_RATE:
            begin
                mul_a = MUL_A_W'(cfg.speed_rate);
                mul_b = MUL_B_W'(speed_sat);
            end
            S_GAIN:
            begin
                mul_a = MUL_A_W'(gain_sat);
                mul_b = MUL_B_W'(ONE_Q16 - exp_reg);
            end
            S_BLEND_X:
            begin
                mul_a = MUL_A_W'(prod_q16);
                mul_b = MUL_B_W'(diff_x_reg);
            end
            S_BLEND_Y, S_FIN:
            begin
                mul_a = MUL_A_W'(blend_b_reg);
                mul_b = MUL_B_W'(diff_y_reg);
            end
            default: ;
        endcase
    end

    // Datapath register updates.
    always_comb
    begin
        seeded_next    = seeded_reg;
        last_x_next    = last_x_reg;
        last_y_next    = last_y_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        diff_x_next    = diff_x_reg;
        diff_y_next    = diff_y_reg;
        speed_next     = speed_reg;
        exp_next       = exp_reg;
        blend_b_next   = blend_b_reg;
        smooth_x_next  = smooth_x_reg;
        smooth_y_next  = smooth_y_reg;
        out_valid_next = out_valid_reg && !out_take;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (seed_point)
                    begin
                        // First point of a path only seeds the smoothed point.
                        last_x_next = point_in.point_x;
                        last_y_next = point_in.point_y;
                        seeded_next = 1'b1;
                    end
                    else
                    begin
                        cur_x_next = point_in.point_x;
                        cur_y_next = point_in.point_y;
                    end
                end
            end
            S_DIST:
            begin
                diff_x_next = dx;
                diff_y_next = dy;
                speed_next  = SPEED_W'(abs_dx) + SPEED_W'(abs_dy);
            end
            S_LOOK:
            begin
                exp_next = EXP_TABLE[exp_idx];
            end
            S_BLEND_X:
            begin
                blend_b_next = prod_q16;
            end
            S_BLEND_Y:
            begin
                last_x_next = blend_val;
            end
            S_FIN:
            begin
                if (fin_go)
                begin
                    last_y_next    = blend_val;
                    smooth_x_next  = last_x_reg;
                    smooth_y_next  = blend_val;
                    out_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            seeded_reg    <= 1'b0;
            last_x_reg    <= '0;
            last_y_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seeded_reg    <= seeded_next;
            last_x_reg    <= last_x_next;
            last_y_reg    <= last_y_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cur_x_reg    <= cur_x_next;
        cur_y_reg    <= cur_y_next;
        diff_x_reg   <= diff_x_next;
        diff_y_reg   <= diff_y_next;
        speed_reg    <= speed_next;
        exp_reg      <= exp_next;
        blend_b_reg  <= blend_b_next;
        smooth_x_reg <= smooth_x_next;
        smooth_y_reg <= smooth_y_next;
    end

    assign smooth_out.valid    = out_valid_reg;
    assign smooth_out.smooth_x = smooth_x_reg;
    assign smooth_out.smooth_y = smooth_y_reg;

`ifndef SYNTH
    // Once a path has been seeded the core never forgets it.
    assert property (@(posedge clk) disable iff (!rst_n) seeded_reg |=> seeded_reg)
        else $error("seeded flag dropped");

    // A blend only runs on a seeded smoothed point.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> seeded_reg)
        else $error("blend sequence without a seeded point");

    // The blend gain never exceeds one in Q1.16.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BLEND_Y) |-> (blend_b_reg <= ONE_Q16))
        else $error("blend gain above one");

    // A path start reseeds with the raw point and leaves the core idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && point_in.path_start) |=>
        ((state_reg == S_IDLE) && (last_x_reg == $past(point_in.point_x))
         && (last_y_reg == $past(point_in.point_y))))
        else $error("path start did not reseed");

    // A finished blend is presented and matches the new smoothed point.
    assert property (@(posedge clk) disable iff (!rst_n)
        fin_go |=> (out_valid_reg && (smooth_x_reg == last_x_reg)
                    && (smooth_y_reg == last_y_reg)))
        else $error("result does not match smoothed point");
`endif

endmodule
